// ===== rtl/core/sensor_loop_fault_monitor_core_defines.svh =====
// assertion macros for the sensor loop fault monitor core
`ifndef SENSOR_LOOP_FAULT_MONITOR_CORE_DEFINES_SVH
`define SENSOR_LOOP_FAULT_MONITOR_CORE_DEFINES_SVH

// same-cycle implication
`define SLFM_ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("slfm assertion failed");

// next-cycle implication
`define SLFM_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("slfm assertion failed");

`endif

// ===== rtl/core/slfm_pkg.sv =====
// types, constants and defaults shared by the fault monitor core
package slfm_pkg;

   localparam int MAX_CHANNELS    = 16;
   localparam int DEF_CHANNELS    = 13;
   localparam int DEF_AVG         = 16;
   localparam int DEF_SAMPLE_BITS = 12;
   localparam int QUEUE_DEPTH     = 2;

   localparam int SAMPLE_W   = 12;
   localparam int THR_W      = 12;
   localparam int SUM_W      = 16;
   localparam int CHAN_IDX_W = 4;
   localparam int SPAN_W     = 16;
   localparam int TIME_W     = 32;
   localparam int STATE_W    = 3;
   localparam int NIBBLE_W   = 4;
   localparam int PACKED_W   = MAX_CHANNELS * NIBBLE_W;
   localparam int BAT_W      = 14;
   localparam int CSR_W      = 16;
   localparam int CSR_IDX_W  = 3;

   // battery scale 115/38, division done as multiply by reciprocal
   localparam int BAT_PROD_W  = 19;
   localparam int BAT_MUL     = 115;
   localparam int BAT_RECIP_W = 20;
   localparam int BAT_RECIP   = 883012;
   localparam int BAT_SHIFT   = 25;

   localparam logic [THR_W-1:0]      RST_SHORT_THR   = 12'd200;
   localparam logic [THR_W-1:0]      RST_WATER_THR   = 12'd1500;
   localparam logic [THR_W-1:0]      RST_OPEN_THR    = 12'd3900;
   localparam logic [CHAN_IDX_W-1:0] RST_BATTERY_CH  = 4'd12;
   localparam logic [SPAN_W-1:0]     RST_DEADTIME    = 16'd10;
   localparam logic [SPAN_W-1:0]     RST_TIMEOUT     = 16'd5000;
   localparam logic [SPAN_W-1:0]     RST_WRITE_DELAY = 16'd1000;

   typedef enum logic [STATE_W-1:0] {
      CH_OK    = 3'd0,
      CH_SHORT = 3'd1,
      CH_WATER = 3'd2,
      CH_OPEN  = 3'd3,
      CH_FAIL  = 3'd4
   } chan_state_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SHORT_THR   = 3'd0,
      CSR_WATER_THR   = 3'd1,
      CSR_OPEN_THR    = 3'd2,
      CSR_BATTERY_CH  = 3'd3,
      CSR_DEADTIME    = 3'd4,
      CSR_TIMEOUT     = 3'd5,
      CSR_WRITE_DELAY = 3'd6
   } csr_index_type;

   typedef enum logic {
      ITEM_SAMPLE = 1'b0,
      ITEM_TICK   = 1'b1
   } item_kind_type;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_ACC,
      SEQ_DIV,
      SEQ_SCALE,
      SEQ_BATT,
      SEQ_MEAS,
      SEQ_DEAD,
      SEQ_SCAN,
      SEQ_REPORT,
      SEQ_DONE
   } seq_state_type;

   typedef struct packed {
      item_kind_type         kind;
      logic [SAMPLE_W-1:0]   sample;
      logic                  ext_ok;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic [THR_W-1:0]      short_thr;
      logic [THR_W-1:0]      water_thr;
      logic [THR_W-1:0]      open_thr;
      logic [CHAN_IDX_W-1:0] battery_ch;
      logic [SPAN_W-1:0]     deadtime;
      logic [SPAN_W-1:0]     timeout;
      logic [SPAN_W-1:0]     write_delay;
   } cfg_type;

endpackage

// ===== rtl/core/slfm_front.sv =====
// input stage: takes a transaction, classifies it and hands it to the queue
module slfm_front #(
   parameter int SAMPLE_BITS = slfm_pkg::DEF_SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic [slfm_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                          req_ext_power_ok,
   input  slfm_pkg::queue_status_type    q_status,
   output logic                          q_push,
   output slfm_pkg::item_type            q_item
);
   import slfm_pkg::*;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((32'd1 << SAMPLE_BITS) - 32'd1);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   item_type item_in;
   logic     accept;

   assign req_stall = valid_ff && q_status.full;
   assign accept    = req_valid && !req_stall;
   assign q_push    = valid_ff && !q_status.full;
   assign q_item    = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in       = 1'b1;
         item_in.kind   = req_command ? ITEM_TICK : ITEM_SAMPLE;
         item_in.sample = req_sample & SAMPLE_MASK;
         item_in.ext_ok = req_ext_power_ok;
      end else if (q_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

// ===== rtl/core/slfm_fifo.sv =====
// short queue of classified transactions between front and back
module slfm_fifo #(
   parameter int DEPTH = slfm_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  slfm_pkg::item_type         push_item,
   input  logic                       pop,
   output slfm_pkg::item_type         pop_item,
   output slfm_pkg::queue_status_type status
);
   import slfm_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type         entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_item     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/core/slfm_back.sv =====
// sequencer that carries out one transaction: averaging, classification, timers, report
module slfm_back #(
   parameter int CHANNELS = slfm_pkg::DEF_CHANNELS,
   parameter int AVG      = slfm_pkg::DEF_AVG
) (
   input  logic                            clock,
   input  logic                            reset,
   input  slfm_pkg::cfg_type               cfg,
   input  slfm_pkg::queue_status_type      q_status,
   input  slfm_pkg::item_type              q_item,
   output logic                            q_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_measured_valid,
   output logic [slfm_pkg::CHAN_IDX_W-1:0] rsp_measured_channel,
   output logic [slfm_pkg::STATE_W-1:0]    rsp_measured_state,
   output logic                            rsp_report,
   output logic [slfm_pkg::PACKED_W-1:0]   rsp_states_packed,
   output logic [slfm_pkg::BAT_W-1:0]      rsp_battery_value
);
   import slfm_pkg::*;

   localparam int CH_W      = $clog2(CHANNELS);
   localparam int CNT_W     = $clog2(AVG + 1);
   localparam int AVG_SHIFT = SUM_W + $clog2(AVG);
   localparam logic [SUM_W:0] AVG_RECIP =
      (SUM_W + 1)'(((64'd1 << AVG_SHIFT) + 64'(AVG) - 64'd1) / 64'(AVG));
   localparam logic [BAT_RECIP_W-1:0] BAT_RECIP_C = BAT_RECIP_W'(BAT_RECIP);

   function automatic chan_state_type classify(input logic [SAMPLE_W-1:0] avg,
                                               input cfg_type c);
      chan_state_type r;
      if (avg < c.short_thr) begin
         r = CH_SHORT;
      end else if (avg < c.water_thr) begin
         r = CH_WATER;
      end else if (avg > c.open_thr) begin
         r = CH_OPEN;
      end else begin
         r = CH_OK;
      end
      return r;
   endfunction

   seq_state_type           seq_ff, seq_in;
   item_type                item_ff, item_in;
   logic [TIME_W-1:0]       now_ff, now_in;
   logic [CH_W-1:0]         cur_ff, cur_in;
   logic [TIME_W-1:0]       switch_stamp_ff, switch_stamp_in;
   logic                    active_ff, active_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [SAMPLE_W-1:0]     avg_ff, avg_in;
   logic [BAT_PROD_W-1:0]   bat_prod_ff, bat_prod_in;
   logic [BAT_W-1:0]        bat_val_ff, bat_val_in;
   chan_state_type          chan_state_ff [CHANNELS];
   chan_state_type          chan_state_in [CHANNELS];
   logic                    pending_ff [CHANNELS];
   logic                    pending_in [CHANNELS];
   logic [TIME_W-1:0]       chan_stamp_ff [CHANNELS];
   logic [TIME_W-1:0]       chan_stamp_in [CHANNELS];
   logic [BAT_W-1:0]        battery_ff, battery_in;
   logic                    changed_ff, changed_in;
   logic [TIME_W-1:0]       report_stamp_ff, report_stamp_in;
   logic [CH_W-1:0]         scan_ff, scan_in;
   logic                    res_valid_ff, res_valid_in;
   logic [CH_W-1:0]         res_chan_ff, res_chan_in;
   chan_state_type          res_state_ff, res_state_in;
   logic                    res_report_ff, res_report_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_meas_ff;
   logic [CHAN_IDX_W-1:0]   rsp_chan_ff;
   chan_state_type          rsp_state_ff;
   logic                    rsp_report_ff;
   logic [PACKED_W-1:0]     rsp_packed_ff;
   logic [BAT_W-1:0]        rsp_battery_ff;

   logic                    is_tick;
   logic                    acc_take;
   logic [CNT_W-1:0]        count_acc;
   logic                    acc_done;
   logic [2*SUM_W:0]        avg_prod;
   logic [BAT_PROD_W+BAT_RECIP_W-1:0] bat_full;
   logic [CH_W-1:0]         rd_idx;
   chan_state_type          rd_state;
   chan_state_type          meas_class;
   logic                    is_batt;
   logic                    dead_due;
   logic                    scan_due;
   logic                    scan_last;
   logic                    report_due;
   logic                    out_free;
   logic                    out_load;
   logic [PACKED_W-1:0]     packed_states;

   assign is_tick   = (item_ff.kind == ITEM_TICK);
   assign acc_take  = !is_tick && active_ff && (count_ff < CNT_W'(AVG));
   assign count_acc = acc_take ? count_ff + CNT_W'(1) : count_ff;
   assign acc_done  = active_ff && (count_acc >= CNT_W'(AVG));

   assign avg_prod = sum_ff * AVG_RECIP;
   assign bat_full = bat_prod_ff * BAT_RECIP_C;

   assign rd_idx     = (seq_ff == SEQ_MEAS) ? cur_ff : scan_ff;
   assign rd_state   = chan_state_ff[rd_idx];
   assign meas_class = classify(avg_ff, cfg);
   assign is_batt    = (cfg.battery_ch == CHAN_IDX_W'(cur_ff));

   assign dead_due   = (now_ff - switch_stamp_ff) >= TIME_W'(cfg.deadtime);
   assign scan_due   = (rd_state != CH_OK) && pending_ff[scan_ff] &&
                       ((now_ff - chan_stamp_ff[scan_ff]) >= TIME_W'(cfg.timeout));
   assign scan_last  = (scan_ff == CH_W'(CHANNELS - 1));
   assign report_due = changed_ff &&
                       ((now_ff - report_stamp_ff) >= TIME_W'(cfg.write_delay));

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign out_load = (seq_ff == SEQ_DONE) && out_free;

   for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_pack
      if (g < CHANNELS) begin : g_used
         assign packed_states[g*NIBBLE_W +: NIBBLE_W] = NIBBLE_W'(chan_state_ff[g]);
      end else begin : g_unused
         assign packed_states[g*NIBBLE_W +: NIBBLE_W] = '0;
      end
   end

   // next state
   always_comb begin
      seq_in = seq_ff;
      case (seq_ff)
         SEQ_IDLE: begin
            if (!q_status.empty) begin
               seq_in = SEQ_ACC;
            end
         end
         SEQ_ACC:    seq_in = acc_done ? SEQ_DIV : SEQ_DEAD;
         SEQ_DIV:    seq_in = SEQ_SCALE;
         SEQ_SCALE:  seq_in = SEQ_BATT;
         SEQ_BATT:   seq_in = SEQ_MEAS;
         SEQ_MEAS:   seq_in = SEQ_DEAD;
         SEQ_DEAD:   seq_in = SEQ_SCAN;
         SEQ_SCAN: begin
            if (scan_last) begin
               seq_in = SEQ_REPORT;
            end
         end
         SEQ_REPORT: seq_in = SEQ_DONE;
         SEQ_DONE: begin
            if (out_free) begin
               seq_in = SEQ_IDLE;
            end
         end
         default:    seq_in = SEQ_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      q_pop           = 1'b0;
      item_in         = item_ff;
      now_in          = now_ff;
      cur_in          = cur_ff;
      switch_stamp_in = switch_stamp_ff;
      active_in       = active_ff;
      sum_in          = sum_ff;
      count_in        = count_ff;
      avg_in          = avg_ff;
      bat_prod_in     = bat_prod_ff;
      bat_val_in      = bat_val_ff;
      chan_state_in   = chan_state_ff;
      pending_in      = pending_ff;
      chan_stamp_in   = chan_stamp_ff;
      battery_in      = battery_ff;
      changed_in      = changed_ff;
      report_stamp_in = report_stamp_ff;
      scan_in         = scan_ff;
      res_valid_in    = res_valid_ff;
      res_chan_in     = res_chan_ff;
      res_state_in    = res_state_ff;
      res_report_in   = res_report_ff;

      case (seq_ff)
         SEQ_IDLE: begin
            if (!q_status.empty) begin
               q_pop         = 1'b1;
               item_in       = q_item;
               res_valid_in  = 1'b0;
               res_chan_in   = '0;
               res_state_in  = CH_OK;
               res_report_in = 1'b0;
            end
         end
         SEQ_ACC: begin
            now_in = now_ff + TIME_W'(is_tick);
            if (acc_take) begin
               sum_in   = sum_ff + SUM_W'(item_ff.sample);
               count_in = count_acc;
            end
         end
         SEQ_DIV: begin
            avg_in = avg_prod[AVG_SHIFT +: SAMPLE_W];
         end
         SEQ_SCALE: begin
            bat_prod_in = BAT_PROD_W'(avg_ff) * BAT_PROD_W'(BAT_MUL);
         end
         SEQ_BATT: begin
            bat_val_in = bat_full[BAT_SHIFT +: BAT_W];
         end
         SEQ_MEAS: begin
            if (is_batt) begin
               if (!item_ff.ext_ok) begin
                  battery_in = bat_val_ff;
                  if (rd_state == CH_OK) begin
                     chan_state_in[cur_ff] = CH_FAIL;
                     pending_in[cur_ff]    = 1'b1;
                     chan_stamp_in[cur_ff] = now_ff - TIME_W'(cfg.timeout);
                     res_state_in          = CH_FAIL;
                  end else begin
                     res_state_in = rd_state;
                  end
               end else begin
                  battery_in            = '0;
                  chan_state_in[cur_ff] = CH_OK;
                  pending_in[cur_ff]    = 1'b0;
                  res_state_in          = CH_OK;
               end
            end else begin
               if (meas_class != CH_OK && rd_state == CH_OK) begin
                  pending_in[cur_ff]    = 1'b1;
                  chan_stamp_in[cur_ff] = now_ff;
               end else if (meas_class == CH_OK && rd_state != CH_OK) begin
                  pending_in[cur_ff] = 1'b0;
               end
               chan_state_in[cur_ff] = meas_class;
               res_state_in          = meas_class;
            end
            res_valid_in    = 1'b1;
            res_chan_in     = cur_ff;
            cur_in          = (cur_ff == CH_W'(CHANNELS - 1)) ? '0 : cur_ff + CH_W'(1);
            switch_stamp_in = now_ff;
            active_in       = 1'b0;
            sum_in          = '0;
            count_in        = '0;
         end
         SEQ_DEAD: begin
            if (!active_ff && dead_due) begin
               switch_stamp_in = now_ff;
               active_in       = 1'b1;
            end
            scan_in = '0;
         end
         SEQ_SCAN: begin
            if (scan_due) begin
               chan_stamp_in[scan_ff] = now_ff;
               pending_in[scan_ff]    = 1'b0;
               changed_in             = 1'b1;
            end
            if (!scan_last) begin
               scan_in = scan_ff + CH_W'(1);
            end
         end
         SEQ_REPORT: begin
            if (report_due) begin
               report_stamp_in = now_ff;
               changed_in      = 1'b0;
               res_report_in   = 1'b1;
               for (int i = 0; i < CHANNELS; i++) begin
                  if (CHAN_IDX_W'(i) != cfg.battery_ch) begin
                     pending_in[i] = 1'b0;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff          <= SEQ_IDLE;
         now_ff          <= '0;
         cur_ff          <= '0;
         switch_stamp_ff <= '0;
         active_ff       <= 1'b0;
         sum_ff          <= '0;
         count_ff        <= '0;
         chan_state_ff   <= '{default: CH_OK};
         pending_ff      <= '{default: 1'b0};
         chan_stamp_ff   <= '{default: '0};
         battery_ff      <= '0;
         changed_ff      <= 1'b0;
         report_stamp_ff <= '0;
         scan_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         seq_ff          <= seq_in;
         now_ff          <= now_in;
         cur_ff          <= cur_in;
         switch_stamp_ff <= switch_stamp_in;
         active_ff       <= active_in;
         sum_ff          <= sum_in;
         count_ff        <= count_in;
         chan_state_ff   <= chan_state_in;
         pending_ff      <= pending_in;
         chan_stamp_ff   <= chan_stamp_in;
         battery_ff      <= battery_in;
         changed_ff      <= changed_in;
         report_stamp_ff <= report_stamp_in;
         scan_ff         <= scan_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      avg_ff        <= avg_in;
      bat_prod_ff   <= bat_prod_in;
      bat_val_ff    <= bat_val_in;
      res_valid_ff  <= res_valid_in;
      res_chan_ff   <= res_chan_in;
      res_state_ff  <= res_state_in;
      res_report_ff <= res_report_in;
      if (out_load) begin
         rsp_meas_ff    <= res_valid_ff;
         rsp_chan_ff    <= CHAN_IDX_W'(res_chan_ff);
         rsp_state_ff   <= res_state_ff;
         rsp_report_ff  <= res_report_ff;
         rsp_packed_ff  <= packed_states;
         rsp_battery_ff <= battery_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_measured_valid   = rsp_meas_ff;
   assign rsp_measured_channel = rsp_chan_ff;
   assign rsp_measured_state   = rsp_state_ff;
   assign rsp_report           = rsp_report_ff;
   assign rsp_states_packed    = rsp_packed_ff;
   assign rsp_battery_value    = rsp_battery_ff;

endmodule

// ===== rtl/core/sensor_loop_fault_monitor_core.sv =====
// Sensor loop fault monitor core, top level.
// req channel: one transaction per ADC sample (command 0) or millisecond tick
// (command 1), with the external power flag. rsp channel: exactly one result
// per request transaction, in order: measurement done flag, channel and state,
// report flag, all channel states packed by nibble and the battery reading.
// csr port: one write per cycle, register index and data, no read-back.
// The back-end sequencer finishes one transaction before it takes the next: it
// visits every channel timer once per transaction and, when the transaction
// completes a channel measurement, also does the average divide, the two
// battery scale multiplies and the channel update.
// A two-entry queue and an input register sit in front of the sequencer, so a
// few requests are taken while a result waits; req_stall rises once they fill.
// While rsp_valid and rsp_stall are both high the result register holds its value unchanged.
// Synchronous reset restores the register defaults, clears all channel
// states, timers and pending flags and empties the queue and result register.
module sensor_loop_fault_monitor_core #(
   parameter int CHANNELS    = slfm_pkg::DEF_CHANNELS,
   parameter int AVG         = slfm_pkg::DEF_AVG,
   parameter int SAMPLE_BITS = slfm_pkg::DEF_SAMPLE_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [slfm_pkg::SAMPLE_W-1:0]   req_sample,
   input  logic                            req_ext_power_ok,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_measured_valid,
   output logic [slfm_pkg::CHAN_IDX_W-1:0] rsp_measured_channel,
   output logic [slfm_pkg::STATE_W-1:0]    rsp_measured_state,
   output logic                            rsp_report,
   output logic [slfm_pkg::PACKED_W-1:0]   rsp_states_packed,
   output logic [slfm_pkg::BAT_W-1:0]      rsp_battery_value,
   input  logic                            csr_write,
   input  logic [slfm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [slfm_pkg::CSR_W-1:0]      csr_wdata
);
   import slfm_pkg::*;

   cfg_type          cfg_ff;
   cfg_type          cfg_in;
   queue_status_type q_status;
   item_type         push_item;
   item_type         pop_item;
   logic             q_push;
   logic             q_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_SHORT_THR:   cfg_in.short_thr   = csr_wdata[THR_W-1:0];
            CSR_WATER_THR:   cfg_in.water_thr   = csr_wdata[THR_W-1:0];
            CSR_OPEN_THR:    cfg_in.open_thr    = csr_wdata[THR_W-1:0];
            CSR_BATTERY_CH:  cfg_in.battery_ch  = csr_wdata[CHAN_IDX_W-1:0];
            CSR_DEADTIME:    cfg_in.deadtime    = csr_wdata[SPAN_W-1:0];
            CSR_TIMEOUT:     cfg_in.timeout     = csr_wdata[SPAN_W-1:0];
            CSR_WRITE_DELAY: cfg_in.write_delay = csr_wdata[SPAN_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_thr   <= RST_SHORT_THR;
         cfg_ff.water_thr   <= RST_WATER_THR;
         cfg_ff.open_thr    <= RST_OPEN_THR;
         cfg_ff.battery_ch  <= RST_BATTERY_CH;
         cfg_ff.deadtime    <= RST_DEADTIME;
         cfg_ff.timeout     <= RST_TIMEOUT;
         cfg_ff.write_delay <= RST_WRITE_DELAY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   slfm_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_sample       (req_sample),
      .req_ext_power_ok (req_ext_power_ok),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_item           (push_item)
   );

   slfm_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   slfm_back #(
      .CHANNELS (CHANNELS),
      .AVG      (AVG)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .q_status             (q_status),
      .q_item               (pop_item),
      .q_pop                (q_pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_measured_valid   (rsp_measured_valid),
      .rsp_measured_channel (rsp_measured_channel),
      .rsp_measured_state   (rsp_measured_state),
      .rsp_report           (rsp_report),
      .rsp_states_packed    (rsp_states_packed),
      .rsp_battery_value    (rsp_battery_value)
   );

endmodule

// ===== rtl/core/slfm_checker.sv =====
// port checker for the fault monitor core and its bind
`include "sensor_loop_fault_monitor_core_defines.svh"

module slfm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic                            rsp_measured_valid,
   input logic [slfm_pkg::CHAN_IDX_W-1:0] rsp_measured_channel,
   input logic [slfm_pkg::STATE_W-1:0]    rsp_measured_state,
   input logic                            rsp_report,
   input logic [slfm_pkg::PACKED_W-1:0]   rsp_states_packed,
   input logic [slfm_pkg::BAT_W-1:0]      rsp_battery_value
);
   import slfm_pkg::*;

   localparam int PAYLOAD_W = 1 + CHAN_IDX_W + STATE_W + 1 + PACKED_W + BAT_W;

   logic [PAYLOAD_W-1:0] payload;
   logic [NIBBLE_W-1:0]  meas_nibble;
   logic                 meas_shown;
   logic                 idle_zero;

   assign payload = {rsp_measured_valid, rsp_measured_channel, rsp_measured_state,
                     rsp_report, rsp_states_packed, rsp_battery_value};
   assign meas_nibble = rsp_states_packed[{rsp_measured_channel, 2'b00} +: NIBBLE_W];
   assign meas_shown  = (meas_nibble == NIBBLE_W'(rsp_measured_state));
   assign idle_zero   = (rsp_measured_channel == '0) && (rsp_measured_state == CH_OK);

   // stalled transaction holds
   `SLFM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(payload))
   // nothing leaves straight after reset
   `SLFM_ASSERT_IMPLY(a_reset_empty, clock, reset, $past(reset), !rsp_valid)
   // no measurement means zero channel and state
   `SLFM_ASSERT_IMPLY(a_idle_fields, clock, reset, rsp_valid && !rsp_measured_valid, idle_zero)
   // measured state agrees with the packed state of that channel
   `SLFM_ASSERT_IMPLY(a_meas_packed, clock, reset, rsp_valid && rsp_measured_valid, meas_shown)

endmodule

bind sensor_loop_fault_monitor_core slfm_checker u_slfm_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_measured_valid   (rsp_measured_valid),
   .rsp_measured_channel (rsp_measured_channel),
   .rsp_measured_state   (rsp_measured_state),
   .rsp_report           (rsp_report),
   .rsp_states_packed    (rsp_states_packed),
   .rsp_battery_value    (rsp_battery_value)
);
